/* rtl/elementwise_reduce_accumulator_top_assert.svh */
// Assertion macros for the element-wise reduction accumulator checker.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef ELEMENTWISE_REDUCE_ACCUMULATOR_TOP_ASSERT_SVH
`define ELEMENTWISE_REDUCE_ACCUMULATOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ERA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ERA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/era_pkg.sv */
// Shared types, codes and helpers of the element-wise reduction accumulator.
// No dependencies.
package era_pkg;

  localparam int ERA_MAX_ELEMS = 256;
  localparam int IDX_W         = 8;
  localparam int VAL_W         = 64;
  localparam int CMD_W         = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int TDATA_W       = IDX_W + VAL_W;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMBINE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  localparam logic [2:0] OP_SUM     = 3'd0;
  localparam logic [2:0] OP_PRODUCT = 3'd1;
  localparam logic [2:0] OP_AND     = 3'd2;
  localparam logic [2:0] OP_OR      = 3'd3;
  localparam logic [2:0] OP_XOR     = 3'd4;
  localparam logic [2:0] OP_MIN     = 3'd5;
  localparam logic [2:0] OP_MAX     = 3'd6;

  localparam logic [1:0] EW_16 = 2'd0;
  localparam logic [1:0] EW_32 = 2'd1;
  localparam logic [1:0] EW_64 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OP_SELECT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd2;

  typedef struct packed {
    logic accept;
    logic rd;
    logic calc;
    logic mul1;
    logic mul2;
    logic finish;
  } era_cmd_t;

  typedef struct packed {
    logic need_mul;
  } era_sts_t;

  function automatic logic [VAL_W-1:0] sext_ew(input logic [VAL_W-1:0] v,
                                               input logic [1:0] ew);
    logic [VAL_W-1:0] r;
    case (ew)
      EW_16:   r = {{48{v[15]}}, v[15:0]};
      EW_32:   r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* rtl/elementwise_reduce_accumulator_top.sv */
// Channel  | Ports                       | Content
// in       | in_tvalid/in_tready         | tuser: command; tdata: index, value
// out      | out_tvalid/out_tready       | tuser: status; tdata: value, index
// cfg      | cfg_we/cfg_index/cfg_data   | op_select, element_width, vector_length
//
// A request passes through accept, memory read, combine and write-back; a product combine
// adds two multiply steps and so passes three times through the shared 32x32 multiplier.
// The accumulator memory has one port, so requests are handled one at a time.
// Reset is synchronous and clears only control and configuration; entries are
// undefined until loaded. A held result stalls write-back, and no new request is
// accepted while it waits.
// Top level; depends on era_pkg, era_ctrl and era_datapath.
module elementwise_reduce_accumulator_top import era_pkg::*; #(
  parameter int MAX_ELEMS = ERA_MAX_ELEMS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // element_index, element_value
  input  logic [CMD_W-1:0]      in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // result_value, result_index
  output logic                  out_tuser   // status
);

  era_cmd_t cmd;
  era_sts_t sts;

  era_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  era_datapath #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

/* rtl/era_ctrl.sv */
// Controller state machine of the element-wise reduction accumulator.
// Depends on era_pkg; drives the datapath through era_cmd_t.
module era_ctrl import era_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  era_sts_t sts,
  output era_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_tvalid;
    cmd.rd     = (state_r == S_READ);
    cmd.calc   = (state_r == S_CALC);
    cmd.mul1   = (state_r == S_MUL1);
    cmd.mul2   = (state_r == S_MUL2);
    cmd.finish = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_READ;
      S_READ: state_nxt = S_CALC;
      S_CALC: state_nxt = sts.need_mul ? S_MUL1 : S_DONE;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_DONE;
      S_DONE: if (cmd.finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* rtl/era_datapath.sv */
// Datapath of the element-wise reduction accumulator: configuration registers,
// accumulator memory, combine unit, shared 32x32 multiplier and output register.
// Depends on era_pkg; steered by era_ctrl.
module era_datapath import era_pkg::*; #(
  parameter int MAX_ELEMS = ERA_MAX_ELEMS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TDATA_W-1:0]    in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  era_cmd_t              cmd,
  output era_sts_t              sts,
  output logic [TDATA_W-1:0]    out_tdata,
  output logic                  out_tuser
);

  localparam int DEPTH = (MAX_ELEMS < (1 << IDX_W)) ? MAX_ELEMS : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [2:0]            op_r;
  logic [1:0]            ew_r;
  logic [CFG_DATA_W-1:0] vlen_r;

  logic [CMD_W-1:0] cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] rdata_r;
  logic [VAL_W-1:0] a_r;
  logic [VAL_W-1:0] res_r;
  logic [VAL_W-1:0] out_val_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_sts_r;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [AW-1:0]    addr;
  logic             in_range;
  logic [VAL_W-1:0] cur;
  logic [VAL_W-1:0] opnd;
  logic [VAL_W-1:0] merged;
  logic [VAL_W-1:0] calc_val;
  logic [VAL_W-1:0] fin_val;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic             do_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_SUM;
      ew_r   <= EW_32;
      vlen_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OP_SELECT:     op_r   <= cfg_data[2:0];
        REG_ELEMENT_WIDTH: ew_r   <= cfg_data[1:0];
        REG_VECTOR_LENGTH: vlen_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign addr     = idx_r[AW-1:0];
  assign in_range = ({1'b0, idx_r} < vlen_r) && ({24'd0, idx_r} < 32'(MAX_ELEMS));
  assign cur      = sext_ew(rdata_r, ew_r);
  assign opnd     = sext_ew(val_r, ew_r);
  assign fin_val  = sext_ew(res_r, ew_r);
  assign do_write = in_range && ((cmd_r == CMD_LOAD) || (cmd_r == CMD_COMBINE));

  assign sts.need_mul = in_range && (cmd_r == CMD_COMBINE) && (op_r == OP_PRODUCT);

  // The low 64 bits of the product are built from three 32x32 partial products.
  always_comb begin
    mul_a = cur[31:0];
    mul_b = opnd[31:0];
    if (cmd.mul1) begin
      mul_a = a_r[31:0];
      mul_b = opnd[63:32];
    end else if (cmd.mul2) begin
      mul_a = a_r[63:32];
      mul_b = opnd[31:0];
    end
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    case (op_r)
      OP_SUM:     merged = cur + opnd;
      OP_PRODUCT: merged = mul_p;
      OP_AND:     merged = cur & opnd;
      OP_OR:      merged = cur | opnd;
      OP_XOR:     merged = cur ^ opnd;
      OP_MIN:     merged = ($signed(opnd) < $signed(cur)) ? opnd : cur;
      OP_MAX:     merged = ($signed(cur) < $signed(opnd)) ? opnd : cur;
      default:    merged = cur;
    endcase
  end

  always_comb begin
    if (!in_range) begin
      calc_val = '0;
    end else begin
      case (cmd_r)
        CMD_LOAD:    calc_val = opnd;
        CMD_COMBINE: calc_val = merged;
        default:     calc_val = cur;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_tuser;
      idx_r <= in_tdata[IDX_W-1:0];
      val_r <= in_tdata[TDATA_W-1:IDX_W];
    end
    if (cmd.calc) begin
      a_r   <= cur;
      res_r <= calc_val;
    end else if (cmd.mul1 || cmd.mul2) begin
      res_r[63:32] <= res_r[63:32] + mul_p[31:0];
    end
    if (cmd.finish) begin
      out_val_r <= fin_val;
      out_idx_r <= idx_r;
      out_sts_r <= !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
    if (cmd.finish && do_write) begin
      mem[addr] <= fin_val;
    end
  end

  assign out_tdata = {out_idx_r, out_val_r};
  assign out_tuser = out_sts_r;

endmodule

/* rtl/era_checker.sv */
// Port-level checker of the element-wise reduction accumulator, bound to the top.
// Depends on era_pkg and the assertion macro header.
`include "elementwise_reduce_accumulator_top_assert.svh"

module era_checker import era_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_W-1:0]    out_tdata,
  input logic                  out_tuser
);

  logic             in_acc;
  logic             out_wait;
  logic             out_flag;
  logic [TDATA_W:0] out_word;

  assign in_acc   = in_tvalid && in_tready;
  assign out_wait = out_tvalid && !out_tready;
  assign out_flag = out_tvalid && out_tuser;
  assign out_word = {out_tuser, out_tdata};

  `ERA_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready, "request accepted while busy")
  `ERA_ASSERT_NEXT(a_no_early_result, in_acc, !$rose(out_tvalid), "result too early")
  `ERA_ASSERT_SAME(a_flag_zero, out_flag, out_tdata[VAL_W-1:0] == '0, "flagged result not zero")
  `ERA_ASSERT_NEXT(a_out_hold, out_wait, out_tvalid && $stable(out_word), "held result changed")

endmodule

bind elementwise_reduce_accumulator_top era_checker u_era_checker (.*);

/* test/tb.sv */
// Self-checking testbench for elementwise_reduce_accumulator_top.
// Drives load, combine and read requests through the input stream, predicts each
// result from a shadow copy of the store and checks the output stream; needs era_pkg.
`timescale 1ns / 100ps

module tb;
  import era_pkg::*;

  localparam logic [2:0]       OP_KEEP      = 3'd7;
  localparam logic [1:0]       EW_WIDE      = 2'd3;
  localparam logic [CMD_W-1:0] CMD_ALT_READ = 2'd3;
  localparam int               IDLE_PCT     = 23;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             status;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata = '0;   // element_index, element_value
  logic [CMD_W-1:0]      in_tuser = '0;   // command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;       // result_value, result_index
  logic                  out_tuser;       // status

  request_t         request_queue[$];
  result_t          expected_results[$];
  logic [VAL_W-1:0] entry_shadow[ERA_MAX_ELEMS];
  bit               entry_loaded[ERA_MAX_ELEMS];
  logic [2:0]       op_shadow = OP_SUM;
  logic [1:0]       width_shadow = EW_32;
  logic [8:0]       length_shadow = 9'd256;
  bit               in_taken = 1'b0;
  bit               steady = 1'b0;
  int               n_issued = 0;
  int               n_taken = 0;
  int               n_errors = 0;
  request_t         next_req;
  result_t          want;

  elementwise_reduce_accumulator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [VAL_W-1:0] at_width(input logic [VAL_W-1:0] v);
    int unsigned sh;
    case (width_shadow)
      EW_16:   sh = 48;
      EW_32:   sh = 32;
      default: sh = 0;
    endcase
    return $unsigned($signed(v << sh) >>> sh);
  endfunction

  // Works out the entry after one request and updates the shadow store.
  function automatic result_t reduce_entry(input logic [CMD_W-1:0] cmd,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [VAL_W-1:0] v);
    result_t          r;
    logic [VAL_W-1:0] cur;
    logic [VAL_W-1:0] opnd;
    logic [VAL_W-1:0] merged;
    r.index  = idx;
    r.value  = '0;
    r.status = 1'b0;
    if ({1'b0, idx} >= length_shadow) begin
      r.status = 1'b1;
    end else begin
      cur  = at_width(entry_shadow[idx]);
      opnd = at_width(v);
      case (cmd)
        CMD_LOAD: begin
          r.value = opnd;
          entry_shadow[idx] = opnd;
        end
        CMD_COMBINE: begin
          case (op_shadow)
            OP_SUM:     merged = cur + opnd;
            OP_PRODUCT: merged = cur * opnd;
            OP_AND:     merged = cur & opnd;
            OP_OR:      merged = cur | opnd;
            OP_XOR:     merged = cur ^ opnd;
            OP_MIN:     merged = ($signed(opnd) < $signed(cur)) ? opnd : cur;
            OP_MAX:     merged = ($signed(cur) < $signed(opnd)) ? opnd : cur;
            default:    merged = cur;
          endcase
          r.value = at_width(merged);
          entry_shadow[idx] = r.value;
        end
        default: begin
          r.value = cur;
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = '0;
      1:       v = '1;
      2:       v = 64'h7FFF_FFFF_FFFF_FFFF;
      3:       v = 64'h8000_0000_0000_0000;
      4:       v = 64'h0000_0000_0000_8000;
      5:       v = 64'h0000_0000_8000_0000;
      6:       v = 64'h0000_0000_0000_7FFF;
      7:       v = {{60{$urandom_range(0, 1) == 1}}, 4'($urandom_range(0, 15))};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // An in-range entry that was never loaded is only ever loaded, never combined or read.
  task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic [VAL_W-1:0] v);
    request_t req;
    req.cmd   = cmd;
    req.index = idx;
    req.value = v;
    if ({1'b0, idx} < length_shadow) begin
      if (cmd != CMD_LOAD && !entry_loaded[idx]) req.cmd = CMD_LOAD;
      if (req.cmd == CMD_LOAD) entry_loaded[idx] = 1'b1;
    end
    request_queue.push_back(req);
    n_issued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    case (idx)
      REG_OP_SELECT:     op_shadow = data[2:0];
      REG_ELEMENT_WIDTH: width_shadow = data[1:0];
      REG_VECTOR_LENGTH: length_shadow = data[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(input int unsigned op, input int unsigned ew, input int unsigned len);
    write_reg(REG_OP_SELECT, op);
    write_reg(REG_ELEMENT_WIDTH, ew);
    write_reg(REG_VECTOR_LENGTH, len);
  endtask

  task automatic drain();
    while (n_taken != n_issued || expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (request_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = request_queue.pop_front();
          in_tuser  <= next_req.cmd;
          in_tdata  <= {next_req.value, next_req.index};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
        in_taken = 1'b0;
      end
      out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(reduce_entry(in_tuser, in_tdata[IDX_W-1:0],
                                                in_tdata[TDATA_W-1:IDX_W]));
        in_taken = 1'b1;
        n_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: value %h index %0d status %0d",
                     out_tdata[VAL_W-1:0], out_tdata[TDATA_W-1:VAL_W], out_tuser);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[VAL_W-1:0] !== want.value || out_tdata[TDATA_W-1:VAL_W] !== want.index
              || out_tuser !== want.status) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected value %h index %0d status %0d, got %h %0d %0d",
                       want.value, want.index, want.status, out_tdata[VAL_W-1:0],
                       out_tdata[TDATA_W-1:VAL_W], out_tuser);
          end
        end
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned op;
    int unsigned ew;
    int unsigned len;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Wrap-around at 64 bits, both ends of the index range and the spare read code.
    set_mode(OP_SUM, EW_64, 256);
    queue_request(CMD_LOAD, 8'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_request(CMD_COMBINE, 8'd0, 64'd1);
    queue_request(CMD_LOAD, 8'd255, 64'h8000_0000_0000_0000);
    queue_request(CMD_READ, 8'd255, '0);
    queue_request(CMD_ALT_READ, 8'd0, '1);
    drain();

    // Every operation but sum at 16 bits on entries loaded at 64 bits, then the spare code.
    write_reg(REG_ELEMENT_WIDTH, EW_16);
    for (int k = 1; k <= 7; k++) begin
      write_reg(REG_OP_SELECT, k);
      queue_request(CMD_COMBINE, 8'd0, 64'h1234_5678_9ABC_8001 + 64'(k * 4099));
      if (k == OP_KEEP) queue_request(CMD_READ, 8'd255, '0);
      drain();
    end

    // A zero length flags every index; the spare width code acts as 64 bits.
    set_mode(OP_MAX, EW_WIDE, 0);
    queue_request(CMD_LOAD, 8'd5, 64'd5);
    queue_request(CMD_READ, 8'd0, '0);
    drain();
    write_reg(REG_VECTOR_LENGTH, 1);
    queue_request(CMD_LOAD, 8'd0, 64'h0123_4567_89AB_CDEF);
    queue_request(CMD_READ, 8'd0, '0);
    queue_request(CMD_LOAD, 8'd1, '1);
    queue_request(CMD_COMBINE, 8'd255, 64'd7);
    queue_request(CMD_COMBINE, 8'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    drain();

    for (int p = 0; p < 9; p++) begin
      op  = ($urandom_range(0, 19) == 0) ? OP_KEEP : $urandom_range(0, 6);
      ew  = ($urandom_range(0, 19) == 0) ? EW_WIDE : $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0:       len = 256;
        1:       len = 1;
        2:       len = $urandom_range(1, 16);
        default: len = $urandom_range(1, 256);
      endcase
      set_mode(op, ew, len);
      steady = (p == 3);
      for (int n = 0; n < 150; n++) begin
        r = $urandom_range(0, 19);
        if (r < 4) cmd = CMD_LOAD;
        else if (r < 15) cmd = CMD_COMBINE;
        else if (r < 19) cmd = CMD_READ;
        else cmd = CMD_ALT_READ;
        idx = ($urandom_range(0, 4) != 0) ? IDX_W'($urandom_range(0, len - 1))
                                          : IDX_W'($urandom_range(0, 255));
        queue_request(cmd, idx, pick_value());
      end
      drain();
      steady = 1'b0;
    end

    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("elementwise_reduce_accumulator_top verification clean");
    end else begin
      $display("elementwise_reduce_accumulator_top verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("elementwise_reduce_accumulator_top verification failed");
    $finish;
  end

endmodule

/* elementwise_reduce_accumulator_top.f */
+incdir+rtl
rtl/era_pkg.sv
rtl/era_ctrl.sv
rtl/era_datapath.sv
rtl/elementwise_reduce_accumulator_top.sv
rtl/era_checker.sv
test/tb.sv
